[hdl/imh_pkg.sv]
// Shared constants and codes for the indexed min-heap core.
package imh_pkg;

   localparam int DEF_CAPACITY    = 1024;
   localparam int DEF_MAX_INSERTS = 1024;

   localparam int VALUE_W  = 32;
   localparam int KEY_W    = 11;
   localparam int COUNT_W  = 11;
   localparam int CMD_W    = 3;
   localparam int STATUS_W = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT   = 3'd0,
      CMD_READ_MIN = 3'd1,
      CMD_DEL_MIN  = 3'd2,
      CMD_DEL_KEY  = 3'd3,
      CMD_MODIFY   = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_DEAD  = 2'd3
   } status_type;

endpackage

[hdl/imh_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module imh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[hdl/indexed_min_heap_core.sv]
// Indexed min-heap core: a binary min-heap of signed values addressable by insertion number.
// Each command transfer (start high while busy is low) yields exactly one result, shown
// for one cycle with rsp_valid; the receiver cannot stall it. Heap entries and the
// insertion-number-to-position map each live in a one-port-write, one-port-read RAM, and
// the sift loops walk one heap level per step: sift-up through S_UP (parent read) and
// S_UP_C (compare and write), sift-down through S_DN_L (left read), S_DN_R (right read)
// and S_DN_C (compare and write). Read minimum and most errors go straight to the
// result; a delete or modify that sifts to a leaf is the longest command. No clearing
// pass is needed after reset: an insertion number is live only if it is not above the
// number of inserts done and its map entry is non-zero.
module indexed_min_heap_core
   import imh_pkg::*;
#(
   parameter int CAPACITY    = DEF_CAPACITY,
   parameter int MAX_INSERTS = DEF_MAX_INSERTS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [CMD_W-1:0]          req_cmd,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic [KEY_W-1:0]          req_key,
   output logic                      rsp_valid,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic signed [VALUE_W-1:0] rsp_min_value,
   output logic [COUNT_W-1:0]        rsp_count
);

   localparam int PW  = $clog2(CAPACITY + 1);
   localparam int AW  = $clog2(CAPACITY);
   localparam int NW  = $clog2(MAX_INSERTS + 1);
   localparam int MAW = $clog2(MAX_INSERTS);
   localparam int CW  = (NW > KEY_W) ? NW : KEY_W;
   localparam int EW  = VALUE_W + NW;

   typedef enum logic [9:0] {
      S_IDLE    = 10'b0000000001,
      S_MAP     = 10'b0000000010,
      S_REM     = 10'b0000000100,
      S_REM_USE = 10'b0000001000,
      S_DN_L    = 10'b0000010000,
      S_DN_R    = 10'b0000100000,
      S_DN_C    = 10'b0001000000,
      S_UP      = 10'b0010000000,
      S_UP_C    = 10'b0100000000,
      S_RESP    = 10'b1000000000
   } state_type;

   state_type                 state_ff, state_in;
   logic [PW-1:0]             count_ff, count_in;
   logic [NW-1:0]             ins_ff, ins_in;
   logic [PW-1:0]             pos_ff, pos_in;
   logic signed [VALUE_W-1:0] cur_val_ff, cur_val_in;
   logic [NW-1:0]             cur_ins_ff, cur_ins_in;
   logic [NW-1:0]             rm_ins_ff, rm_ins_in;
   logic                      moved_ff, moved_in;
   logic                      is_mod_ff, is_mod_in;
   status_type                status_ff, status_in;
   logic signed [VALUE_W-1:0] l_val_ff, l_val_in;
   logic [NW-1:0]             l_ins_ff, l_ins_in;
   logic signed [VALUE_W-1:0] root_val_ff, root_val_in;
   logic [NW-1:0]             root_ins_ff, root_ins_in;

   logic                      heap_we, heap_re;
   logic [AW-1:0]             heap_waddr, heap_raddr;
   logic [EW-1:0]             heap_wdata, heap_rdata;
   logic                      map_we, map_re;
   logic [MAW-1:0]            map_waddr, map_raddr;
   logic [PW-1:0]             map_wdata, map_rdata;

   logic signed [VALUE_W-1:0] rd_val;
   logic [NW-1:0]             rd_ins;
   logic [PW:0]               lpos, rpos;
   logic                      has_l, has_r;
   logic signed [VALUE_W-1:0] lv, cmpv;
   logic [NW-1:0]             li;
   logic                      use_l, use_r;
   logic                      accept;

   assign rd_val = heap_rdata[EW-1:NW];
   assign rd_ins = heap_rdata[NW-1:0];
   assign lpos   = {pos_ff, 1'b0};
   assign rpos   = {pos_ff, 1'b1};
   assign has_l  = lpos <= {1'b0, count_ff};
   assign has_r  = rpos <= {1'b0, count_ff};
   assign accept = start && (state_ff == S_IDLE);

   // Child selection for sift-down: left first, right only if strictly smaller still.
   assign lv    = (state_ff == S_DN_C) ? l_val_ff : rd_val;
   assign li    = (state_ff == S_DN_C) ? l_ins_ff : rd_ins;
   assign use_l = lv < cur_val_ff;
   assign cmpv  = use_l ? lv : cur_val_ff;
   assign use_r = (state_ff == S_DN_C) && (rd_val < cmpv);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      ins_in      = ins_ff;
      pos_in      = pos_ff;
      cur_val_in  = cur_val_ff;
      cur_ins_in  = cur_ins_ff;
      rm_ins_in   = rm_ins_ff;
      moved_in    = moved_ff;
      is_mod_in   = is_mod_ff;
      status_in   = status_ff;
      l_val_in    = l_val_ff;
      l_ins_in    = l_ins_ff;
      root_val_in = root_val_ff;
      root_ins_in = root_ins_ff;
      heap_we     = 1'b0;
      heap_waddr  = AW'(pos_ff - PW'(1));
      heap_wdata  = {cur_val_ff, cur_ins_ff};
      heap_re     = 1'b0;
      heap_raddr  = AW'(count_ff - PW'(1));
      map_we      = 1'b0;
      map_waddr   = MAW'(cur_ins_ff - NW'(1));
      map_wdata   = pos_ff;
      map_re      = 1'b0;
      map_raddr   = MAW'(req_key - KEY_W'(1));

      case (state_ff)
         S_IDLE: begin
            moved_in   = 1'b0;
            status_in  = ST_OK;
            cur_val_in = req_value;
            is_mod_in  = (req_cmd == CMD_MODIFY);
            if (accept) begin
               state_in = S_RESP;
               case (req_cmd)
                  CMD_INSERT: begin
                     if (count_ff == PW'(CAPACITY) || ins_ff == NW'(MAX_INSERTS)) begin
                        status_in = ST_FULL;
                     end else begin
                        count_in   = count_ff + PW'(1);
                        ins_in     = ins_ff + NW'(1);
                        pos_in     = count_ff + PW'(1);
                        cur_ins_in = ins_ff + NW'(1);
                        state_in   = S_UP;
                     end
                  end
                  CMD_READ_MIN: begin
                     if (count_ff == '0) status_in = ST_EMPTY;
                  end
                  CMD_DEL_MIN: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        rm_ins_in = root_ins_ff;
                        pos_in    = PW'(1);
                        state_in  = S_REM;
                     end
                  end
                  CMD_DEL_KEY, CMD_MODIFY: begin
                     if (req_key == '0 || CW'(req_key) > CW'(ins_ff)) begin
                        status_in = ST_DEAD;
                     end else begin
                        map_re     = 1'b1;
                        rm_ins_in  = NW'(req_key);
                        cur_ins_in = NW'(req_key);
                        state_in   = S_MAP;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_MAP: begin
            pos_in = map_rdata;
            if (map_rdata == '0) begin
               status_in = ST_DEAD;
               state_in  = S_RESP;
            end else if (is_mod_ff) begin
               state_in = S_DN_L;
            end else begin
               state_in = S_REM;
            end
         end
         S_REM: begin
            heap_re  = 1'b1;
            state_in = S_REM_USE;
         end
         S_REM_USE: begin
            cur_val_in = rd_val;
            cur_ins_in = rd_ins;
            map_we     = 1'b1;
            map_waddr  = MAW'(rm_ins_ff - NW'(1));
            map_wdata  = '0;
            count_in   = count_ff - PW'(1);
            state_in   = (pos_ff == count_ff) ? S_RESP : S_DN_L;
         end
         S_DN_L: begin
            if (has_l) begin
               heap_re    = 1'b1;
               heap_raddr = AW'(lpos - (PW + 1)'(1));
               state_in   = S_DN_R;
            end else if (moved_ff) begin
               heap_we  = 1'b1;
               map_we   = 1'b1;
               state_in = S_RESP;
            end else begin
               state_in = S_UP;
            end
         end
         S_DN_R, S_DN_C: begin
            if (state_ff == S_DN_R && has_r) begin
               l_val_in   = rd_val;
               l_ins_in   = rd_ins;
               heap_re    = 1'b1;
               heap_raddr = AW'(rpos - (PW + 1)'(1));
               state_in   = S_DN_C;
            end else if (use_r || use_l) begin
               // Move the smaller child up into the hole and follow it down.
               heap_we    = 1'b1;
               heap_wdata = use_r ? {rd_val, rd_ins} : {lv, li};
               map_we     = 1'b1;
               map_waddr  = MAW'((use_r ? rd_ins : li) - NW'(1));
               pos_in     = use_r ? PW'(rpos) : PW'(lpos);
               moved_in   = 1'b1;
               state_in   = S_DN_L;
            end else if (moved_ff) begin
               heap_we  = 1'b1;
               map_we   = 1'b1;
               state_in = S_RESP;
            end else begin
               state_in = S_UP;
            end
         end
         S_UP: begin
            if (pos_ff == PW'(1)) begin
               heap_we  = 1'b1;
               map_we   = 1'b1;
               state_in = S_RESP;
            end else begin
               heap_re    = 1'b1;
               heap_raddr = AW'((pos_ff >> 1) - PW'(1));
               state_in   = S_UP_C;
            end
         end
         S_UP_C: begin
            heap_we = 1'b1;
            map_we  = 1'b1;
            if (rd_val > cur_val_ff) begin
               heap_wdata = {rd_val, rd_ins};
               map_waddr  = MAW'(rd_ins - NW'(1));
               pos_in     = pos_ff >> 1;
               state_in   = S_UP;
            end else begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // The root entry is mirrored so the minimum is always at hand.
      if (heap_we && heap_waddr == '0) begin
         root_val_in = heap_wdata[EW-1:NW];
         root_ins_in = heap_wdata[NW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         ins_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ins_ff   <= ins_in;
      end
      pos_ff      <= pos_in;
      cur_val_ff  <= cur_val_in;
      cur_ins_ff  <= cur_ins_in;
      rm_ins_ff   <= rm_ins_in;
      moved_ff    <= moved_in;
      is_mod_ff   <= is_mod_in;
      status_ff   <= status_in;
      l_val_ff    <= l_val_in;
      l_ins_ff    <= l_ins_in;
      root_val_ff <= root_val_in;
      root_ins_ff <= root_ins_in;
   end

   imh_ram #(
      .WIDTH (EW),
      .DEPTH (CAPACITY)
   ) u_heap_ram (
      .clock   (clock),
      .wr_en   (heap_we),
      .wr_addr (heap_waddr),
      .wr_data (heap_wdata),
      .rd_en   (heap_re),
      .rd_addr (heap_raddr),
      .rd_data (heap_rdata)
   );

   imh_ram #(
      .WIDTH (PW),
      .DEPTH (MAX_INSERTS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_en   (map_re),
      .rd_addr (map_raddr),
      .rd_data (map_rdata)
   );

   assign busy          = (state_ff != S_IDLE);
   assign rsp_valid     = (state_ff == S_RESP);
   assign rsp_status    = status_ff;
   assign rsp_min_value = (count_ff == '0) ? '0 : root_val_ff;
   assign rsp_count     = COUNT_W'(count_ff);

`ifndef SYNTH
   a_resp_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result shown while not busy");
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("transfer accepted but core not busy");
   a_count_cap : assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(CAPACITY)) else $error("entry count above capacity");
   a_count_ins : assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(ins_ff)) else $error("more entries than inserts done");
   a_resp_once : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result shown for more than one cycle");
`endif

endmodule

[verif/imh_checker.sv]
// Checker for the indexed min-heap core: predicts each result and compares it.
module imh_checker
   import imh_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  logic [CMD_W-1:0]          req_cmd,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic [KEY_W-1:0]          req_key,
   input  logic                      rsp_valid,
   input  logic [STATUS_W-1:0]       rsp_status,
   input  logic signed [VALUE_W-1:0] rsp_min_value,
   input  logic [COUNT_W-1:0]        rsp_count,
   output int                        fail_count,
   output int                        pending_results,
   output int                        ok_results,
   output int                        error_results
);

   localparam int CAP  = DEF_CAPACITY;
   localparam int MAXI = DEF_MAX_INSERTS;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] min_value;
      logic [COUNT_W-1:0]        count;
   } heap_result_type;

   logic signed [VALUE_W-1:0] heap_val [0:CAP];
   int                        slot_owner [0:CAP];
   int                        owner_slot [0:MAXI];
   int                        heap_size;
   int                        inserts_used;
   heap_result_type           expected_results [$];

   assign pending_results = expected_results.size();

   function automatic void swap_slots(int a, int b);
      int na, nb;
      logic signed [VALUE_W-1:0] tv;
      na = slot_owner[a];
      nb = slot_owner[b];
      owner_slot[na] = b;
      owner_slot[nb] = a;
      slot_owner[a] = nb;
      slot_owner[b] = na;
      tv = heap_val[a];
      heap_val[a] = heap_val[b];
      heap_val[b] = tv;
   endfunction

   function automatic void restore_order(int p);
      int best, l;
      forever begin
         best = p;
         l = 2 * p;
         if (l <= heap_size && heap_val[l] < heap_val[best]) best = l;
         if (l + 1 <= heap_size && heap_val[l+1] < heap_val[best]) best = l + 1;
         if (best == p) break;
         swap_slots(p, best);
         p = best;
      end
      while (p > 1 && heap_val[p/2] > heap_val[p]) begin
         swap_slots(p / 2, p);
         p = p / 2;
      end
   endfunction

   function automatic void take_out(int p);
      int last;
      last = heap_size;
      swap_slots(p, last);
      owner_slot[slot_owner[last]] = 0;
      heap_size--;
      if (p <= heap_size) restore_order(p);
   endfunction

   function automatic heap_result_type apply_command(logic [CMD_W-1:0] cmd,
                                                     logic signed [VALUE_W-1:0] val,
                                                     logic [KEY_W-1:0] key);
      heap_result_type r;
      logic [STATUS_W-1:0] st;
      bit live;
      st = ST_OK;
      live = key >= 1 && key <= MAXI && owner_slot[key] != 0;
      case (cmd)
         CMD_INSERT: begin
            if (heap_size >= CAP || inserts_used >= MAXI) st = ST_FULL;
            else begin
               heap_size++;
               inserts_used++;
               owner_slot[inserts_used] = heap_size;
               slot_owner[heap_size] = inserts_used;
               heap_val[heap_size] = val;
               restore_order(heap_size);
            end
         end
         CMD_READ_MIN: if (heap_size == 0) st = ST_EMPTY;
         CMD_DEL_MIN: begin
            if (heap_size == 0) st = ST_EMPTY;
            else take_out(1);
         end
         CMD_DEL_KEY: begin
            if (!live) st = ST_DEAD;
            else take_out(owner_slot[key]);
         end
         CMD_MODIFY: begin
            if (!live) st = ST_DEAD;
            else begin
               heap_val[owner_slot[key]] = val;
               restore_order(owner_slot[key]);
            end
         end
         default: ;
      endcase
      r.status = st;
      r.min_value = heap_size != 0 ? heap_val[1] : '0;
      r.count = heap_size[COUNT_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      heap_result_type got, want;
      if (reset) begin
         heap_size = 0;
         inserts_used = 0;
         for (int i = 0; i <= MAXI; i++) owner_slot[i] = 0;
         fail_count <= 0;
         ok_results <= 0;
         error_results <= 0;
         expected_results.delete();
      end else begin
         if (rsp_valid) begin
            got = '{rsp_status, rsp_min_value, rsp_count};
            if (expected_results.size() == 0) begin
               $display("%0t: result with nothing expected: got %p", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (got.status != want.status || got.min_value !== want.min_value ||
                   got.count != want.count) begin
                  $display({"%0t: mismatch: expected status %0d min %0d count %0d, ",
                            "got status %0d min %0d count %0d"},
                           $time, want.status, want.min_value, want.count,
                           got.status, got.min_value, got.count);
                  fail_count <= fail_count + 1;
               end
               if (want.status == ST_OK) ok_results <= ok_results + 1;
               else error_results <= error_results + 1;
            end
         end
         // The prediction is pushed after the pop, so a same-edge result is never confused.
         if (start && !busy) begin
            expected_results.push_back(apply_command(req_cmd, req_value, req_key));
         end
      end
   end

endmodule

[verif/tb_top.sv]
// Testbench top for the indexed min-heap core: stimulus, watchdog and verdict.
module tb_top;
   import imh_pkg::*;

   localparam int TOTAL_ITEMS = 1850;
   localparam int IDLE_LIMIT  = 5000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [CMD_W-1:0]          req_cmd = CMD_READ_MIN;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic [KEY_W-1:0]          req_key = '0;
   logic                      rsp_valid;
   logic [STATUS_W-1:0]       rsp_status;
   logic signed [VALUE_W-1:0] rsp_min_value;
   logic [COUNT_W-1:0]        rsp_count;
   int                        fail_count, pending_results, ok_results, error_results;
   int                        idle_cycles = 0;
   int                        issued = 0;
   int                        keys_issued = 0;

   always #2 clock = ~clock;

   indexed_min_heap_core i_dut (.*);

   imh_checker i_checker (.*);

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout after %0d quiet cycles", idle_cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

   // One command transfer, after a random gap when asked for. Start stays high into the
   // next command when there is no gap; the core ignores it while busy.
   task automatic send_command(logic [CMD_W-1:0] cmd, logic signed [VALUE_W-1:0] val,
                               logic [KEY_W-1:0] key, bit with_gap);
      int gap;
      gap = with_gap ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_cmd <= cmd;
      req_value <= val;
      req_key <= key;
      if (cmd == CMD_INSERT) keys_issued++;
      do @(posedge clock); while (busy);
      issued++;
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         2: return $urandom;
         default: return $signed($urandom_range(0, 40)) - 20;
      endcase
   endfunction

   // Mostly keys that may still be live, with some dead, zero and out-of-range ones.
   function automatic logic [KEY_W-1:0] pick_key();
      case ($urandom_range(0, 9))
         0: return KEY_W'($urandom);
         1: return 11'd0;
         default: return keys_issued == 0 ? 11'd1
                                          : KEY_W'($urandom_range(1, keys_issued));
      endcase
   endfunction

   initial begin
      bit gaps;
      int c;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty heap errors, extremes, every command, dead keys, unknown codes.
      send_command(CMD_READ_MIN, 0, 0, 0);
      send_command(CMD_DEL_MIN, 0, 0, 0);
      send_command(CMD_DEL_KEY, 0, 11'd1, 0);
      send_command(CMD_MODIFY, 5, 11'd0, 0);
      send_command(CMD_INSERT, 32'sh7FFFFFFF, 0, 0);
      send_command(CMD_INSERT, 32'sh80000000, 11'h7FF, 0);
      send_command(CMD_INSERT, 0, 0, 0);
      send_command(CMD_INSERT, -1, 0, 0);
      send_command(CMD_READ_MIN, 0, 0, 0);
      send_command(CMD_MODIFY, 32'sh7FFFFFFF, 11'd2, 0);
      send_command(CMD_MODIFY, 32'sh80000000, 11'd1, 0);
      send_command(CMD_DEL_KEY, 0, 11'd3, 0);
      send_command(CMD_DEL_KEY, 0, 11'd3, 0);
      send_command(CMD_MODIFY, 1, 11'd3, 0);
      send_command(CMD_DEL_KEY, 0, 11'h7FF, 0);
      send_command(CMD_MODIFY, 1, 11'd1025, 0);
      send_command(3'd5, -1, 11'h7FF, 0);
      send_command(3'd6, 0, 0, 0);
      send_command(3'd7, 0, 0, 0);
      send_command(CMD_DEL_MIN, 0, 0, 0);
      send_command(CMD_DEL_MIN, 0, 0, 0);
      send_command(CMD_DEL_MIN, 0, 0, 0);

      // Random: a growing phase, a mixed phase and a draining phase; insert numbers
      // stay below 1024, so the tail does not reach the full status.
      for (int n = 0; n < TOTAL_ITEMS; n++) begin
         gaps = (n / 200) % 2 == 1;
         c = $urandom_range(0, 99);
         if (n < 700) begin
            if (c < 60) send_command(CMD_INSERT, pick_value(), pick_key(), gaps);
            else if (c < 70) send_command(CMD_DEL_MIN, $urandom, KEY_W'($urandom), gaps);
            else if (c < 80) send_command(CMD_DEL_KEY, $urandom, pick_key(), gaps);
            else if (c < 92) send_command(CMD_MODIFY, pick_value(), pick_key(), gaps);
            else if (c < 97) send_command(CMD_READ_MIN, $urandom, KEY_W'($urandom), gaps);
            else send_command(CMD_W'($urandom_range(5, 7)), $urandom, KEY_W'($urandom),
                              gaps);
         end else if (n < 1400) begin
            if (c < 40) send_command(CMD_INSERT, pick_value(), pick_key(), gaps);
            else if (c < 55) send_command(CMD_DEL_MIN, 0, 0, gaps);
            else if (c < 70) send_command(CMD_DEL_KEY, 0, pick_key(), gaps);
            else if (c < 90) send_command(CMD_MODIFY, pick_value(), pick_key(), gaps);
            else send_command(CMD_READ_MIN, 0, 0, gaps);
         end else begin
            if (c < 50) send_command(CMD_DEL_MIN, 0, 0, gaps);
            else if (c < 70) send_command(CMD_DEL_KEY, 0, pick_key(), gaps);
            else if (c < 85) send_command(CMD_INSERT, pick_value(), 0, gaps);
            else send_command(CMD_READ_MIN, 0, 0, gaps);
         end
      end
      start <= 1'b0;

      while (pending_results != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("Sent %0d commands: %0d ok results and %0d error results checked.",
               issued, ok_results, error_results);
      if (fail_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
